>>> hdl/stp_pkg.sv
// Shared types and constants for the stepper step generator.
package stp_pkg;

    // Request kinds carried in the mode field
    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_LOAD    = 2'd1,
        MODE_ENABLE  = 2'd2,
        MODE_DISABLE = 2'd3
    } t_mode;

    // Direction of travel; code three is loaded as still
    typedef enum logic [1:0] {
        HEAD_STILL = 2'd0,
        HEAD_INC   = 2'd1,
        HEAD_DEC   = 2'd2
    } t_heading;

    // Bit positions in the limit event field
    localparam int EVT_MAX_BIT = 0;
    localparam int EVT_MIN_BIT = 1;

    // Reset values; the position is cut to the counter width where it is used
    localparam logic [31:0] RESET_PERIOD   = 32'd10000;
    localparam logic [63:0] RESET_POSITION = 64'd10000;

    // One input request
    typedef struct packed {
        t_mode              mode;
        logic               min_switch_level;
        logic               max_switch_level;
        logic signed [31:0] move_steps;
        logic [1:0]         move_direction;
    } t_request;

    // One result
    typedef struct packed {
        logic               step_pulse;
        logic               direction_pin;
        logic               enable_pin_n;
        logic signed [31:0] position;
        logic signed [31:0] remaining;
        logic               min_hit;
        logic               max_hit;
        logic [1:0]         limit_event;
    } t_result;

endpackage

>>> hdl/stp_req_if.sv
// Request channel: valid/ready handshake with the input payload.
interface stp_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic               min_switch_level;
    logic               max_switch_level;
    logic signed [31:0] move_steps;
    logic [1:0]         move_direction;

    modport source (
        output valid, mode, min_switch_level, max_switch_level, move_steps,
               move_direction,
        input  ready
    );
    modport sink (
        input  valid, mode, min_switch_level, max_switch_level, move_steps,
               move_direction,
        output ready
    );
endinterface

>>> hdl/stp_rsp_if.sv
// Result channel: valid/ready handshake with the result payload.
interface stp_rsp_if;
    logic               valid;
    logic               ready;
    logic               step_pulse;
    logic               direction_pin;
    logic               enable_pin_n;
    logic signed [31:0] position;
    logic signed [31:0] remaining;
    logic               min_hit;
    logic               max_hit;
    logic [1:0]         limit_event;

    modport source (
        output valid, step_pulse, direction_pin, enable_pin_n, position, remaining,
               min_hit, max_hit, limit_event,
        input  ready
    );
    modport sink (
        input  valid, step_pulse, direction_pin, enable_pin_n, position, remaining,
               min_hit, max_hit, limit_event,
        output ready
    );
endinterface

>>> hdl/stp_core.sv
// Channel state, period register and the per-request update logic.
module stp_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [31:0]      i_cfg_data,
    input  logic             i_accept,
    input  stp_pkg::t_request i_req,
    output stp_pkg::t_result o_result
);

    localparam int CW = COUNT_WIDTH;

    logic [31:0]         r_period;
    logic                r_pulse,   n_pulse;
    logic                r_enabled, n_enabled;
    stp_pkg::t_heading   r_heading, n_heading;
    logic [CW-1:0]       r_pos,     n_pos;
    logic [CW-1:0]       r_count,   n_count;
    logic [CW-1:0]       r_timer,   n_timer;
    logic                r_reload,  n_reload;
    logic                r_min,     n_min;
    logic                r_max,     n_max;
    logic [1:0]          n_event;

    logic [63:0]         period_ext;
    logic [63:0]         steps_ext;
    logic [63:0]         pos_ext;
    logic [63:0]         count_ext;

    assign period_ext = {32'd0, r_period};
    assign steps_ext  = {{32{i_req.move_steps[31]}}, i_req.move_steps};

    // Next state for one request
    always_comb begin
        n_pulse   = r_pulse;
        n_enabled = r_enabled;
        n_heading = r_heading;
        n_pos     = r_pos;
        n_count   = r_count;
        n_timer   = r_timer;
        n_reload  = r_reload;
        n_min     = r_min;
        n_max     = r_max;
        n_event   = 2'b00;
        case (i_req.mode)
            stp_pkg::MODE_TICK: begin
                // drop pulse, count down or take a step opportunity
                n_pulse = 1'b0;
                if (r_enabled && (r_count != '0)) begin
                    if (r_timer != '0) begin
                        n_timer = r_timer - CW'(1);
                    end else if (r_reload) begin
                        if ((r_heading == stp_pkg::HEAD_INC) && !r_max) begin
                            n_pos   = r_pos + CW'(1);
                            n_count = r_count + CW'(1);
                            n_pulse = 1'b1;
                        end else if ((r_heading == stp_pkg::HEAD_DEC) && !r_min) begin
                            n_pos   = r_pos - CW'(1);
                            n_count = r_count - CW'(1);
                            n_pulse = 1'b1;
                        end
                        n_reload = 1'b0;
                    end
                end
                // end stops, low level means hit
                n_min = !i_req.min_switch_level;
                n_max = !i_req.max_switch_level;
                // reverse away from a hit stop, then reload the timer
                if (!n_reload && (n_count != '0)) begin
                    if (n_max && (n_heading == stp_pkg::HEAD_INC)) begin
                        n_heading = stp_pkg::HEAD_DEC;
                        n_count   = '0;
                        n_event[stp_pkg::EVT_MAX_BIT] = 1'b1;
                    end
                    if (n_min && (n_heading == stp_pkg::HEAD_DEC)) begin
                        n_heading = stp_pkg::HEAD_INC;
                        n_count   = '0;
                        n_event[stp_pkg::EVT_MIN_BIT] = 1'b1;
                    end
                    n_timer  = period_ext[CW-1:0];
                    n_reload = 1'b1;
                end
            end
            stp_pkg::MODE_LOAD: begin
                if ((i_req.move_direction == stp_pkg::HEAD_INC) ||
                    (i_req.move_direction == stp_pkg::HEAD_DEC)) begin
                    n_heading = stp_pkg::t_heading'(i_req.move_direction);
                end else begin
                    n_heading = stp_pkg::HEAD_STILL;
                end
                n_count = steps_ext[CW-1:0];
            end
            stp_pkg::MODE_ENABLE: begin
                n_enabled = 1'b1;
            end
            stp_pkg::MODE_DISABLE: begin
                n_enabled = 1'b0;
            end
            default: begin
                n_enabled = r_enabled;
            end
        endcase
    end

    // Result fields, low 32 bits of the counters
    assign pos_ext   = 64'(n_pos);
    assign count_ext = 64'(n_count);

    always_comb begin
        o_result.step_pulse    = n_pulse;
        o_result.direction_pin = (n_heading == stp_pkg::HEAD_INC);
        o_result.enable_pin_n  = !n_enabled;
        o_result.position      = pos_ext[31:0];
        o_result.remaining     = count_ext[31:0];
        o_result.min_hit       = n_min;
        o_result.max_hit       = n_max;
        o_result.limit_event   = n_event;
    end

    // Period register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= stp_pkg::RESET_PERIOD;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_data;
        end
    end

    // State update on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse   <= 1'b0;
            r_enabled <= 1'b0;
            r_heading <= stp_pkg::HEAD_STILL;
            r_pos     <= stp_pkg::RESET_POSITION[CW-1:0];
            r_count   <= '0;
            r_timer   <= '0;
            r_reload  <= 1'b0;
            r_min     <= 1'b0;
            r_max     <= 1'b0;
        end else if (i_accept) begin
            r_pulse   <= n_pulse;
            r_enabled <= n_enabled;
            r_heading <= n_heading;
            r_pos     <= n_pos;
            r_count   <= n_count;
            r_timer   <= n_timer;
            r_reload  <= n_reload;
            r_min     <= n_min;
            r_max     <= n_max;
        end
    end

    // A step always moves the position
    a_step_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (i_req.mode == stp_pkg::MODE_TICK) && n_pulse)
        |=> (r_pos != $past(r_pos)))
        else $error("step pulse without position change");

    // A limit reversal always clears the move count
    a_event_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (n_event != 2'b00)) |-> (n_count == '0))
        else $error("limit event with nonzero count");

    // After a tick a live move always has a reload pending
    a_reload_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (i_req.mode == stp_pkg::MODE_TICK))
        |=> ((r_count == '0) || r_reload))
        else $error("live move without pending reload");

endmodule

>>> hdl/stp_out_stage.sv
// Result register that drives the result channel.
module stp_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  stp_pkg::t_result i_result,
    output logic             o_space,
    stp_rsp_if.source        o_rsp
);

    logic             r_valid;
    stp_pkg::t_result r_data;

    // Room for a new result when empty or the held one leaves this cycle
    assign o_space = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_result;
        end
    end

    assign o_rsp.valid         = r_valid;
    assign o_rsp.step_pulse    = r_data.step_pulse;
    assign o_rsp.direction_pin = r_data.direction_pin;
    assign o_rsp.enable_pin_n  = r_data.enable_pin_n;
    assign o_rsp.position      = r_data.position;
    assign o_rsp.remaining     = r_data.remaining;
    assign o_rsp.min_hit       = r_data.min_hit;
    assign o_rsp.max_hit       = r_data.max_hit;
    assign o_rsp.limit_event   = r_data.limit_event;

endmodule

>>> hdl/stepper_step_generator.sv
// Top level of one stepper step/direction pulse channel.
//
// Use one instance per motor. Requests arrive on i_req: a tick of the step
// timebase (with both end-stop pin levels), a move load, or a driver enable or
// disable. Every request gives exactly one result on o_rsp carrying the step,
// direction and enable pin levels, position, remaining count, end-stop flags
// and the limit event of that request.
// The step period register is to be written via i_cfg_we/i_cfg_data by the
// user only while idle; the block does not enforce it. The state update is
// done in the cycle a request is accepted and the result register presents it
// on the next cycle. One request per cycle is sustained unless the receiver
// stalls; the rate is set by the single result register. The held result then
// stays and i_req.ready drops until it is taken; ready follows o_rsp.ready
// combinationally. Reset (synchronous, active low) clears the result register,
// disables the driver, stops motion and sets position and period to 10000.
module stepper_step_generator #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    stp_req_if.sink     i_req,
    stp_rsp_if.source   o_rsp
);

    logic              space;
    logic              accept;
    stp_pkg::t_request req;
    stp_pkg::t_result  result;

    // Handshake on the request side
    assign i_req.ready = space;
    assign accept      = i_req.valid && space;

    // Payload as a struct for the core
    always_comb begin
        req.mode             = stp_pkg::t_mode'(i_req.mode);
        req.min_switch_level = i_req.min_switch_level;
        req.max_switch_level = i_req.max_switch_level;
        req.move_steps       = i_req.move_steps;
        req.move_direction   = i_req.move_direction;
    end

    stp_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_req      (req),
        .o_result   (result)
    );

    stp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_result (result),
        .o_space  (space),
        .o_rsp    (o_rsp)
    );

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the stepper step generator: directed and random requests.
module tb_top;

    localparam int CYCLE_LIMIT = 500000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_data;

    stp_req_if req_ch ();
    stp_rsp_if rsp_ch ();

    stepper_step_generator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    // Channel state mirrored by the bench
    logic [31:0]       ch_period;
    bit                ch_pulse;
    bit                ch_enabled;
    stp_pkg::t_heading ch_heading;
    logic [31:0]       ch_position;
    logic [31:0]       ch_count;
    logic [31:0]       ch_timer;
    bit                ch_reload;
    bit                ch_min;
    bit                ch_max;

    stp_pkg::t_result awaited_results[$];
    int               mismatch_count;
    int               items_sent;
    int               cycle_count;
    bit               idle_on;
    int               rx_hold_len;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** stepper_step_generator: FAILED **");
        $finish;
    end

    // Apply one request to the mirrored channel and return the result it gives
    function automatic stp_pkg::t_result advance_channel(stp_pkg::t_request r);
        stp_pkg::t_result res;
        logic [1:0]       evt;
        evt = '0;
        case (r.mode)
            stp_pkg::MODE_TICK: begin
                ch_pulse = 1'b0;
                if (ch_enabled && ch_count != 0) begin
                    if (ch_timer != 0) begin
                        ch_timer = ch_timer - 1;
                    end else if (ch_reload) begin
                        if (ch_heading == stp_pkg::HEAD_INC && !ch_max) begin
                            ch_position = ch_position + 1;
                            ch_count    = ch_count + 1;
                            ch_pulse    = 1'b1;
                        end else if (ch_heading == stp_pkg::HEAD_DEC && !ch_min) begin
                            ch_position = ch_position - 1;
                            ch_count    = ch_count - 1;
                            ch_pulse    = 1'b1;
                        end
                        ch_reload = 1'b0;
                    end
                end
                // pins are low when hit
                ch_min = !r.min_switch_level;
                ch_max = !r.max_switch_level;
                if (!ch_reload && ch_count != 0) begin
                    if (ch_max && ch_heading == stp_pkg::HEAD_INC) begin
                        ch_heading                = stp_pkg::HEAD_DEC;
                        ch_count                  = '0;
                        evt[stp_pkg::EVT_MAX_BIT] = 1'b1;
                    end
                    if (ch_min && ch_heading == stp_pkg::HEAD_DEC) begin
                        ch_heading                = stp_pkg::HEAD_INC;
                        ch_count                  = '0;
                        evt[stp_pkg::EVT_MIN_BIT] = 1'b1;
                    end
                    ch_timer  = ch_period;
                    ch_reload = 1'b1;
                end
            end
            stp_pkg::MODE_LOAD: begin
                if (r.move_direction == stp_pkg::HEAD_INC ||
                    r.move_direction == stp_pkg::HEAD_DEC)
                    ch_heading = stp_pkg::t_heading'(r.move_direction);
                else
                    ch_heading = stp_pkg::HEAD_STILL;
                ch_count = r.move_steps;
            end
            stp_pkg::MODE_ENABLE: ch_enabled = 1'b1;
            default:              ch_enabled = 1'b0;
        endcase
        res.step_pulse    = ch_pulse;
        res.direction_pin = (ch_heading == stp_pkg::HEAD_INC);
        res.enable_pin_n  = !ch_enabled;
        res.position      = ch_position;
        res.remaining     = ch_count;
        res.min_hit       = ch_min;
        res.max_hit       = ch_max;
        res.limit_event   = evt;
        return res;
    endfunction

    function automatic stp_pkg::t_request make_request(stp_pkg::t_mode m, bit min_l,
                                                       bit max_l, int steps,
                                                       logic [1:0] dir);
        stp_pkg::t_request r;
        r.mode             = m;
        r.min_switch_level = min_l;
        r.max_switch_level = max_l;
        r.move_steps       = steps;
        r.move_direction   = dir;
        return r;
    endfunction

    task automatic flag_mismatch(string what);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // Result checker
    always @(posedge i_clk) begin
        stp_pkg::t_result want;
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (awaited_results.size() == 0) begin
                flag_mismatch("result with no request outstanding");
            end else begin
                want = awaited_results.pop_front();
                check_field("step_pulse", 32'(rsp_ch.step_pulse), 32'(want.step_pulse));
                check_field("direction_pin", 32'(rsp_ch.direction_pin),
                            32'(want.direction_pin));
                check_field("enable_pin_n", 32'(rsp_ch.enable_pin_n),
                            32'(want.enable_pin_n));
                check_field("position", rsp_ch.position, want.position);
                check_field("remaining", rsp_ch.remaining, want.remaining);
                check_field("min_hit", 32'(rsp_ch.min_hit), 32'(want.min_hit));
                check_field("max_hit", 32'(rsp_ch.max_hit), 32'(want.max_hit));
                check_field("limit_event", 32'(rsp_ch.limit_event), 32'(want.limit_event));
            end
        end
    end

    // Receiver: random stall bursts and the occasional long hold-off
    initial begin
        int stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (rx_hold_len > 0) begin
                stall_left   = rx_hold_len - 1;
                rx_hold_len  = 0;
                rsp_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left   = $urandom_range(0, 16);
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Offer one request, wait for acceptance; starts and ends at a falling edge
    task automatic send_request(stp_pkg::t_request r);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        req_ch.valid            <= 1'b1;
        req_ch.mode             <= r.mode;
        req_ch.min_switch_level <= r.min_switch_level;
        req_ch.max_switch_level <= r.max_switch_level;
        req_ch.move_steps       <= r.move_steps;
        req_ch.move_direction   <= r.move_direction;
        @(posedge i_clk);
        while (!(req_ch.valid === 1'b1 && req_ch.ready === 1'b1)) @(posedge i_clk);
        awaited_results.push_back(advance_channel(r));
        items_sent++;
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every result is back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_step_period(logic [31:0] value);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        ch_period  = value;
        @(negedge i_clk);
    endtask

    // Random moves: enable, load a move, a run of ticks; some noise mixed in
    task automatic run_moves(int n_items);
        int                stop_at;
        int                steps;
        int                n_ticks;
        logic [1:0]        dir;
        stp_pkg::t_request r;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 15) == 0) begin
                r = make_request(stp_pkg::t_mode'($urandom_range(0, 3)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 $urandom, 2'($urandom_range(0, 3)));
                send_request(r);
            end else begin
                if ($urandom_range(0, 3) == 0 || !ch_enabled)
                    send_request(make_request(stp_pkg::MODE_ENABLE,
                                              1'($urandom_range(0, 1)),
                                              1'($urandom_range(0, 1)), $urandom,
                                              stp_pkg::HEAD_STILL));
                case ($urandom_range(0, 9))
                    0:       steps = $urandom;
                    1:       steps = 0;
                    default: begin
                        steps = $urandom_range(1, 12);
                        if ($urandom_range(0, 1) == 1) steps = -steps;
                    end
                endcase
                if ($urandom_range(0, 5) == 0)
                    dir = 2'($urandom_range(0, 3));
                else
                    dir = (steps < 0) ? stp_pkg::HEAD_INC : stp_pkg::HEAD_DEC;
                send_request(make_request(stp_pkg::MODE_LOAD, 1'b1, 1'b1, steps, dir));
                n_ticks = $urandom_range(4, 30);
                repeat (n_ticks) begin
                    if ($urandom_range(0, 39) == 0)
                        send_request(make_request(stp_pkg::MODE_DISABLE, 1'b1, 1'b1, 0,
                                                  stp_pkg::HEAD_STILL));
                    send_request(make_request(stp_pkg::MODE_TICK,
                                              $urandom_range(0, 19) != 0,
                                              $urandom_range(0, 19) != 0, $urandom,
                                              2'($urandom_range(0, 3))));
                end
            end
        end
    endtask

    // Outputs straight after reset, with a zero count so no reload is armed
    task automatic test_reset_outputs();
        send_request(make_request(stp_pkg::MODE_DISABLE, 1'b0, 1'b0, 0,
                                  stp_pkg::HEAD_STILL));
        send_request(make_request(stp_pkg::MODE_TICK, 1'b1, 1'b1, 0, stp_pkg::HEAD_STILL));
        send_request(make_request(stp_pkg::MODE_LOAD, 1'b1, 1'b1, 0, stp_pkg::HEAD_INC));
    endtask

    // Field extremes, every request kind, stops and the odd directions
    task automatic test_directed_cases();
        write_step_period(32'd0);
        send_request(make_request(stp_pkg::MODE_LOAD, 1'b1, 1'b1, 3, stp_pkg::HEAD_DEC));
        // disabled: reload armed, timer held
        send_request(make_request(stp_pkg::MODE_TICK, 1'b1, 1'b1, 0, stp_pkg::HEAD_STILL));
        send_request(make_request(stp_pkg::MODE_TICK, 1'b1, 1'b1, 0, stp_pkg::HEAD_STILL));
        // commands ignore the pins
        send_request(make_request(stp_pkg::MODE_ENABLE, 1'b0, 1'b0, -1, 2'd3));
        send_request(make_request(stp_pkg::MODE_TICK, 1'b1, 1'b1, 0, stp_pkg::HEAD_STILL));
        send_request(make_request(stp_pkg::MODE_TICK, 1'b1, 1'b1, 0, stp_pkg::HEAD_STILL));
        send_request(make_request(stp_pkg::MODE_TICK, 1'b0, 1'b1, 0, stp_pkg::HEAD_STILL));
        // max stop hit while increasing
        send_request(make_request(stp_pkg::MODE_LOAD, 1'b0, 1'b0, 32'h7fff_ffff,
                                  stp_pkg::HEAD_INC));
        send_request(make_request(stp_pkg::MODE_TICK, 1'b1, 1'b0, 0, stp_pkg::HEAD_STILL));
        // min stop hit while decreasing, count wraps on the step
        send_request(make_request(stp_pkg::MODE_LOAD, 1'b1, 1'b1, 32'h8000_0000,
                                  stp_pkg::HEAD_DEC));
        send_request(make_request(stp_pkg::MODE_TICK, 1'b0, 1'b1, 0, stp_pkg::HEAD_STILL));
        // both stops hit while increasing
        send_request(make_request(stp_pkg::MODE_LOAD, 1'b1, 1'b1, 7, stp_pkg::HEAD_INC));
        send_request(make_request(stp_pkg::MODE_TICK, 1'b0, 1'b0, 0, stp_pkg::HEAD_STILL));
        // direction code three and still heading with a count
        send_request(make_request(stp_pkg::MODE_LOAD, 1'b1, 1'b1, 5, 2'd3));
        send_request(make_request(stp_pkg::MODE_TICK, 1'b1, 1'b1, 0, stp_pkg::HEAD_STILL));
        send_request(make_request(stp_pkg::MODE_TICK, 1'b1, 1'b1, 0, stp_pkg::HEAD_STILL));
        send_request(make_request(stp_pkg::MODE_LOAD, 1'b1, 1'b1, 4, stp_pkg::HEAD_STILL));
        send_request(make_request(stp_pkg::MODE_TICK, 1'b1, 1'b1, 0, stp_pkg::HEAD_STILL));
        // zero count tick, a disabled tick, then a negative count
        send_request(make_request(stp_pkg::MODE_LOAD, 1'b1, 1'b1, 0, stp_pkg::HEAD_INC));
        send_request(make_request(stp_pkg::MODE_TICK, 1'b1, 1'b1, 0, stp_pkg::HEAD_STILL));
        send_request(make_request(stp_pkg::MODE_DISABLE, 1'b1, 1'b1, 0,
                                  stp_pkg::HEAD_STILL));
        send_request(make_request(stp_pkg::MODE_TICK, 1'b1, 1'b1, 0, stp_pkg::HEAD_STILL));
        send_request(make_request(stp_pkg::MODE_ENABLE, 1'b1, 1'b1, 0,
                                  stp_pkg::HEAD_STILL));
        send_request(make_request(stp_pkg::MODE_LOAD, 1'b1, 1'b1, -2, stp_pkg::HEAD_INC));
        send_request(make_request(stp_pkg::MODE_TICK, 1'b1, 1'b1, 0, stp_pkg::HEAD_STILL));
        send_request(make_request(stp_pkg::MODE_TICK, 1'b1, 1'b1, 0, stp_pkg::HEAD_STILL));
    endtask

    // Receiver holds off long while requests keep coming
    task automatic test_receiver_hold_off();
        write_step_period(32'd1);
        idle_on     = 1'b0;
        rx_hold_len = 300;
        run_moves(40);
        idle_on     = 1'b1;
    endtask

    // Random moves over a spread of small periods, with idling
    task automatic test_random_moves();
        write_step_period(32'd1);
        run_moves(330);
        write_step_period(32'd2);
        run_moves(330);
        write_step_period(32'd4);
        run_moves(330);
        write_step_period($urandom_range(0, 7));
        run_moves(330);
    endtask

    // Last part without idling; the widest period goes at the very end since
    // a timer reloaded with it never runs out within the run
    task automatic test_period_extremes();
        idle_on = 1'b0;
        write_step_period(32'd0);
        run_moves(200);
        write_step_period(32'hffff_ffff);
        run_moves(100);
    endtask

    // Sequencer
    initial begin
        i_rst_n                 = 1'b0;
        i_cfg_we                = 1'b0;
        i_cfg_data              = '0;
        req_ch.valid            = 1'b0;
        req_ch.mode             = stp_pkg::MODE_TICK;
        req_ch.min_switch_level = 1'b1;
        req_ch.max_switch_level = 1'b1;
        req_ch.move_steps       = '0;
        req_ch.move_direction   = stp_pkg::HEAD_STILL;
        mismatch_count          = 0;
        items_sent              = 0;
        idle_on                 = 1'b1;
        rx_hold_len             = 0;

        ch_period   = stp_pkg::RESET_PERIOD;
        ch_pulse    = 1'b0;
        ch_enabled  = 1'b0;
        ch_heading  = stp_pkg::HEAD_STILL;
        ch_position = stp_pkg::RESET_POSITION[31:0];
        ch_count    = '0;
        ch_timer    = '0;
        ch_reload   = 1'b0;
        ch_min      = 1'b0;
        ch_max      = 1'b0;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_outputs();
        test_directed_cases();
        test_receiver_hold_off();
        test_random_moves();
        test_period_extremes();

        drain_results();
        repeat (10) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("** stepper_step_generator: PASSED **");
        end else begin
            $display("** stepper_step_generator: FAILED **");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/stp_pkg.sv
hdl/stp_req_if.sv
hdl/stp_rsp_if.sv
hdl/stp_core.sv
hdl/stp_out_stage.sv
hdl/stepper_step_generator.sv
bench/tb_top.sv
